/* hw/rtl/mpcr_pkg.sv */
// Shared types and constants of the MIDI port and channel router.
`default_nettype none

package mpcr_pkg;

  localparam int unsigned PortW      = 4;
  localparam int unsigned TypeW      = 8;
  localparam int unsigned ChanW      = 5;
  localparam int unsigned DataW      = 7;
  localparam int unsigned Channels   = 16;
  localparam int unsigned ChIdxW     = 4;
  localparam int unsigned MapW       = Channels * ChanW;
  localparam int unsigned RowW       = MapW + 1;
  localparam int unsigned QueueDepth = 2;

  localparam logic [PortW-1:0] UsbInPort = 4'd7;
  localparam logic [TypeW-1:0] SysexType = 8'hF0;
  localparam logic [TypeW-1:0] SysBase   = 8'hF0;

  typedef enum logic [1:0] {
    KindWrite,
    KindSys,
    KindChan
  } kind_e;

  // One accepted beat after classification.
  typedef struct packed {
    kind_e              kind;
    logic [PortW-1:0]   port;
    logic [TypeW-1:0]   msg_type;
    logic [ChanW-1:0]   chan;
    logic [DataW-1:0]   data_one;
    logic [DataW-1:0]   data_two;
    logic [PortW-1:0]   wport;
    logic               wen;
    logic [ChanW-1:0]   wtarget;
  } item_t;

  // Identity channel map: entry c holds channel c+1.
  function automatic logic [MapW-1:0] identity_map();
    logic [MapW-1:0] m;
    for (int c = 0; c < int'(Channels); c++) begin
      m[c*ChanW +: ChanW] = ChanW'(c + 1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mpcr_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none

module mpcr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/mpcr_front.sv */
// Front end: accepts command beats, drops ones that do nothing, classifies the rest.
`default_nettype none

module mpcr_front #(
  parameter int unsigned IN_PORTS  = 10,
  parameter int unsigned OUT_PORTS = 5,
  localparam int unsigned DestW = (OUT_PORTS > 1) ? $clog2(OUT_PORTS) : 1
) (
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          command_i,
  input  wire logic [mpcr_pkg::PortW-1:0]    in_port_i,
  input  wire logic                          msg_valid_i,
  input  wire logic [mpcr_pkg::TypeW-1:0]    msg_type_i,
  input  wire logic [mpcr_pkg::ChanW-1:0]    msg_channel_i,
  input  wire logic [mpcr_pkg::DataW-1:0]    data_one_i,
  input  wire logic [mpcr_pkg::DataW-1:0]    data_two_i,
  input  wire logic [DestW-1:0]              out_port_i,
  input  wire logic                          route_enable_i,
  input  wire logic [mpcr_pkg::ChanW-1:0]    target_channel_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output mpcr_pkg::item_t                    q_item_o
);

  logic port_ok, wport_ok, chan_ok, is_sys, keep;

  always_comb begin
    port_ok  = 32'(in_port_i) < IN_PORTS;
    wport_ok = 32'(out_port_i) < OUT_PORTS;
    chan_ok  = (msg_channel_i >= 5'd1) &&
               (32'(msg_channel_i) <= mpcr_pkg::Channels);
    is_sys   = msg_type_i >= mpcr_pkg::SysBase;

    if (command_i) begin
      keep = port_ok && wport_ok && chan_ok;
    end else begin
      // channel messages on a bad channel forward nothing
      keep = port_ok && msg_valid_i && (msg_type_i != '0) && (is_sys || chan_ok);
    end

    q_item_o.kind     = command_i ? mpcr_pkg::KindWrite :
                        (is_sys ? mpcr_pkg::KindSys : mpcr_pkg::KindChan);
    q_item_o.port     = in_port_i;
    q_item_o.msg_type = msg_type_i;
    q_item_o.chan     = msg_channel_i;
    q_item_o.data_one = data_one_i;
    q_item_o.data_two = data_two_i;
    q_item_o.wport    = mpcr_pkg::PortW'(out_port_i);
    q_item_o.wen      = route_enable_i;
    q_item_o.wtarget  = target_channel_i;
  end

  assign busy_o   = q_full_i;
  assign q_push_o = start_i && !q_full_i && keep;

endmodule

`default_nettype wire

/* hw/rtl/mpcr_fifo.sv */
// Short queue of classified beats between front and back end.
`default_nettype none

module mpcr_fifo #(
  parameter int unsigned Depth = 2,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mpcr_pkg::item_t push_item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output mpcr_pkg::item_t      head_o
);

  mpcr_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mpcr_back.sv */
// Back end: walks the destinations through the route RAM and issues copies, or merges one table write.
`default_nettype none

module mpcr_back #(
  parameter int unsigned IN_PORTS  = 10,
  parameter int unsigned OUT_PORTS = 5,
  localparam int unsigned DestW = (OUT_PORTS > 1) ? $clog2(OUT_PORTS) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_empty_i,
  input  wire mpcr_pkg::item_t             q_head_i,
  output logic                             q_pop_o,
  output logic                             strobe_o,
  output logic [DestW-1:0]                 dest_port_o,
  output logic [mpcr_pkg::TypeW-1:0]       out_type_o,
  output logic [mpcr_pkg::ChanW-1:0]       out_channel_o,
  output logic [mpcr_pkg::DataW-1:0]       out_data_one_o,
  output logic [mpcr_pkg::DataW-1:0]       out_data_two_o,
  output logic                             last_o
);

  localparam int unsigned Rows  = IN_PORTS * OUT_PORTS;
  localparam int unsigned AddrW = (Rows > 1) ? $clog2(Rows) : 1;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StDrain  = 3'd2;
  localparam logic [2:0] StFlush  = 3'd3;
  localparam logic [2:0] StWrRead = 3'd4;
  localparam logic [2:0] StWrMod  = 3'd5;

  localparam logic [DestW-1:0] LastDest = DestW'(OUT_PORTS - 1);

  function automatic logic [AddrW-1:0] row_addr(logic [mpcr_pkg::PortW-1:0] p,
                                                logic [mpcr_pkg::PortW-1:0] d);
    return AddrW'(32'(p) * OUT_PORTS + 32'(d));
  endfunction

  // a port does not loop back to itself; usb input maps to the last destination
  function automatic logic is_self(logic [mpcr_pkg::PortW-1:0] p,
                                   logic [mpcr_pkg::PortW-1:0] d);
    if (32'(d) == OUT_PORTS - 1) begin
      return p == mpcr_pkg::UsbInPort;
    end
    return p == d;
  endfunction

  logic [2:0]                   state_q, state_d;
  mpcr_pkg::item_t              cur_q, cur_d;
  logic [DestW-1:0]             dest_q, dest_d;
  logic                         chk_q, chk_d;
  logic [DestW-1:0]             chk_dest_q, chk_dest_d;
  logic                         rd_vld_q;
  logic                         pend_q, pend_d;
  logic [DestW-1:0]             pend_dest_q, pend_dest_d;
  logic [mpcr_pkg::ChanW-1:0]   pend_chan_q, pend_chan_d;
  logic                         emit;
  logic [Rows-1:0]              row_valid_q;

  logic [AddrW-1:0]             raddr;
  logic [mpcr_pkg::RowW-1:0]    rdata, base_row, wdata;
  logic                         we;

  logic [mpcr_pkg::ChIdxW-1:0]  ch_idx;
  logic                         en, hit;
  logic [mpcr_pkg::ChanW-1:0]   oc;

  mpcr_ram #(
    .Width (mpcr_pkg::RowW),
    .Depth (Rows)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (raddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ch_idx = mpcr_pkg::ChIdxW'(cur_q.chan - 5'd1);

  // classify the row that arrived for chk_dest_q
  always_comb begin
    en  = rd_vld_q ? rdata[mpcr_pkg::MapW]
                   : !is_self(cur_q.port, mpcr_pkg::PortW'(chk_dest_q));
    oc  = cur_q.chan;
    hit = 1'b0;
    if (cur_q.kind == mpcr_pkg::KindSys) begin
      hit = en && !((chk_dest_q == LastDest) && (cur_q.msg_type == mpcr_pkg::SysexType));
    end else begin
      if (rd_vld_q) begin
        oc = rdata[ch_idx*mpcr_pkg::ChanW +: mpcr_pkg::ChanW];
      end
      hit = en && (oc >= 5'd1) && (32'(oc) <= mpcr_pkg::Channels);
    end
  end

  // merge one write into the stored row, or into the reset row if never written
  always_comb begin
    if (rd_vld_q) begin
      base_row = rdata;
    end else begin
      base_row = {!is_self(cur_q.port, cur_q.wport), mpcr_pkg::identity_map()};
    end
    wdata = base_row;
    wdata[mpcr_pkg::MapW] = cur_q.wen;
    wdata[ch_idx*mpcr_pkg::ChanW +: mpcr_pkg::ChanW] = cur_q.wtarget;
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    dest_d      = dest_q;
    chk_d       = 1'b0;
    chk_dest_d  = dest_q;
    pend_d      = pend_q;
    pend_dest_d = pend_dest_q;
    pend_chan_d = pend_chan_q;
    q_pop_o     = 1'b0;
    we          = 1'b0;
    emit        = 1'b0;
    raddr       = row_addr(cur_q.port, cur_q.wport);

    // hold each hit until the next one shows whether it is the last copy
    if (chk_q && hit) begin
      emit        = pend_q;
      pend_d      = 1'b1;
      pend_dest_d = chk_dest_q;
      pend_chan_d = oc;
    end

    case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_head_i;
          dest_d  = '0;
          pend_d  = 1'b0;
          state_d = (q_head_i.kind == mpcr_pkg::KindWrite) ? StWrRead : StScan;
        end
      end
      StScan: begin
        raddr      = row_addr(cur_q.port, mpcr_pkg::PortW'(dest_q));
        chk_d      = 1'b1;
        chk_dest_d = dest_q;
        if (dest_q == LastDest) begin
          state_d = StDrain;
        end else begin
          dest_d = dest_q + 1'b1;
        end
      end
      StDrain: begin
        state_d = StFlush;
      end
      StFlush: begin
        emit    = pend_q;
        pend_d  = 1'b0;
        state_d = StIdle;
      end
      StWrRead: begin
        state_d = StWrMod;
      end
      StWrMod: begin
        we      = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      chk_q       <= 1'b0;
      pend_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      strobe_o    <= 1'b0;
      row_valid_q <= '0;
    end else begin
      state_q  <= state_d;
      chk_q    <= chk_d;
      pend_q   <= pend_d;
      rd_vld_q <= row_valid_q[raddr];
      strobe_o <= emit;
      if (we) begin
        row_valid_q[raddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    dest_q      <= dest_d;
    chk_dest_q  <= chk_dest_d;
    pend_dest_q <= pend_dest_d;
    pend_chan_q <= pend_chan_d;
    if (emit) begin
      dest_port_o    <= pend_dest_q;
      out_type_o     <= cur_q.msg_type;
      out_channel_o  <= pend_chan_q;
      out_data_one_o <= cur_q.data_one;
      out_data_two_o <= cur_q.data_two;
      last_o         <= state_q == StFlush;
    end
  end

  a_last_from_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |-> $past(state_q) == StFlush)
    else $error("last copy issued outside flush");

  a_strobe_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(chk_q) || $past(state_q) == StFlush)
    else $error("copy issued without a checked row");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> !pend_q && !chk_q)
    else $error("pending copy left behind after a message");

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> state_q == StIdle && !strobe_o)
    else $error("table write overlapped routing");

endmodule

`default_nettype wire

/* hw/rtl/midi_port_channel_router.sv */
// Top level of the MIDI port and channel router.
`default_nettype none

// Command channel: a beat is taken on a rising edge with start high and busy low.
// command_i = 0 routes a decoded message arriving on in_port_i; command_i = 1 writes
// the route enable bit and one channel map entry for (in_port_i, out_port_i,
// msg_channel_i). Beats that can do nothing are dropped at the front.
// Result channel: each forwarded copy is shown for one cycle with strobe_o high;
// last_o marks the final copy of a message. The receiver cannot stall: copies
// are issued at most one per cycle and must be taken as they come.
// A routed message holds the back end through a pop, one route RAM row read per
// destination, a drain and a flush; a write holds it through a pop, a read, and
// the merge and write of one RAM row. A copy is issued once the next hit, or the
// flush, shows whether it is the last; later copies follow as hits arrive.
// A two-entry queue lets the front take beats while the back end works; busy is
// high only while that queue is full.
// Reset: the queue empties and all route rows read as their reset contents
// (identity channel map, every route enabled except a port to itself) until
// written; no clearing pass is needed, so beats are taken right after reset.
module midi_port_channel_router #(
  parameter int unsigned IN_PORTS  = 10,
  parameter int unsigned OUT_PORTS = 5,
  localparam int unsigned DestW = (OUT_PORTS > 1) ? $clog2(OUT_PORTS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          command_i,
  input  wire logic [mpcr_pkg::PortW-1:0]    in_port_i,
  input  wire logic                          msg_valid_i,
  input  wire logic [mpcr_pkg::TypeW-1:0]    msg_type_i,
  input  wire logic [mpcr_pkg::ChanW-1:0]    msg_channel_i,
  input  wire logic [mpcr_pkg::DataW-1:0]    data_one_i,
  input  wire logic [mpcr_pkg::DataW-1:0]    data_two_i,
  input  wire logic [DestW-1:0]              out_port_i,
  input  wire logic                          route_enable_i,
  input  wire logic [mpcr_pkg::ChanW-1:0]    target_channel_i,
  output logic                               strobe_o,
  output logic [DestW-1:0]                   dest_port_o,
  output logic [mpcr_pkg::TypeW-1:0]         out_type_o,
  output logic [mpcr_pkg::ChanW-1:0]         out_channel_o,
  output logic [mpcr_pkg::DataW-1:0]         out_data_one_o,
  output logic [mpcr_pkg::DataW-1:0]         out_data_two_o,
  output logic                               last_o
);

  logic            q_push, q_full, q_pop, q_empty;
  mpcr_pkg::item_t q_in, q_head;

  mpcr_front #(
    .IN_PORTS  (IN_PORTS),
    .OUT_PORTS (OUT_PORTS)
  ) u_front (
    .start_i          (start),
    .busy_o           (busy),
    .command_i        (command_i),
    .in_port_i        (in_port_i),
    .msg_valid_i      (msg_valid_i),
    .msg_type_i       (msg_type_i),
    .msg_channel_i    (msg_channel_i),
    .data_one_i       (data_one_i),
    .data_two_i       (data_two_i),
    .out_port_i       (out_port_i),
    .route_enable_i   (route_enable_i),
    .target_channel_i (target_channel_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_item_o         (q_in)
  );

  mpcr_fifo #(
    .Depth (mpcr_pkg::QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  mpcr_back #(
    .IN_PORTS  (IN_PORTS),
    .OUT_PORTS (OUT_PORTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .strobe_o       (strobe_o),
    .dest_port_o    (dest_port_o),
    .out_type_o     (out_type_o),
    .out_channel_o  (out_channel_o),
    .out_data_one_o (out_data_one_o),
    .out_data_two_o (out_data_two_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the MIDI port and channel router.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned InPorts  = 10;
  localparam int unsigned OutPorts = 5;
  localparam int unsigned DestW    = $clog2(OutPorts);
  localparam int unsigned UsbDest  = OutPorts - 1;
  localparam int unsigned NumItems = 180;
  localparam int unsigned CalmTail = 40;

  localparam logic CmdRoute = 1'b0;
  localparam logic CmdWrite = 1'b1;

  localparam logic [mpcr_pkg::TypeW-1:0] TypeNone   = 8'h00;
  localparam logic [mpcr_pkg::TypeW-1:0] NoteOff    = 8'h80;
  localparam logic [mpcr_pkg::TypeW-1:0] NoteOn     = 8'h90;
  localparam logic [mpcr_pkg::TypeW-1:0] PolyPress  = 8'hA0;
  localparam logic [mpcr_pkg::TypeW-1:0] CtrlChange = 8'hB0;
  localparam logic [mpcr_pkg::TypeW-1:0] ProgChange = 8'hC0;
  localparam logic [mpcr_pkg::TypeW-1:0] ChanPress  = 8'hD0;
  localparam logic [mpcr_pkg::TypeW-1:0] PitchBend  = 8'hE0;
  localparam logic [mpcr_pkg::TypeW-1:0] TimingClk  = 8'hF8;
  localparam logic [mpcr_pkg::TypeW-1:0] SysReset   = 8'hFF;

  localparam logic [mpcr_pkg::ChanW-1:0] ChanDrop = 5'd17;

  typedef struct {
    logic                       cmd;
    logic [mpcr_pkg::PortW-1:0] port;
    logic                       vld;
    logic [mpcr_pkg::TypeW-1:0] mtype;
    logic [mpcr_pkg::ChanW-1:0] chan;
    logic [mpcr_pkg::DataW-1:0] d1;
    logic [mpcr_pkg::DataW-1:0] d2;
    logic [DestW-1:0]           wport;
    logic                       wen;
    logic [mpcr_pkg::ChanW-1:0] wtarget;
  } beat_t;

  typedef struct {
    logic [DestW-1:0]           dest;
    logic [mpcr_pkg::TypeW-1:0] mtype;
    logic [mpcr_pkg::ChanW-1:0] chan;
    logic [mpcr_pkg::DataW-1:0] d1;
    logic [mpcr_pkg::DataW-1:0] d2;
    logic                       last;
  } copy_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic                       command_i        = 1'b0;
  logic [mpcr_pkg::PortW-1:0] in_port_i        = '0;
  logic                       msg_valid_i      = 1'b0;
  logic [mpcr_pkg::TypeW-1:0] msg_type_i       = '0;
  logic [mpcr_pkg::ChanW-1:0] msg_channel_i    = '0;
  logic [mpcr_pkg::DataW-1:0] data_one_i       = '0;
  logic [mpcr_pkg::DataW-1:0] data_two_i       = '0;
  logic [DestW-1:0]           out_port_i       = '0;
  logic                       route_enable_i   = 1'b0;
  logic [mpcr_pkg::ChanW-1:0] target_channel_i = '0;
  logic                       strobe_o;
  logic [DestW-1:0]           dest_port_o;
  logic [mpcr_pkg::TypeW-1:0] out_type_o;
  logic [mpcr_pkg::ChanW-1:0] out_channel_o;
  logic [mpcr_pkg::DataW-1:0] out_data_one_o;
  logic [mpcr_pkg::DataW-1:0] out_data_two_o;
  logic                       last_o;

  // Mirror of the routing tables
  logic                       route_en [InPorts][OutPorts];
  logic [mpcr_pkg::ChanW-1:0] chan_map [InPorts][OutPorts][mpcr_pkg::Channels];

  beat_t pending_q[$];
  copy_t copies_q[$];
  int    n_errors = 0;
  int    gap_left = 0;

  midi_port_channel_router #(
    .IN_PORTS (InPorts),
    .OUT_PORTS(OutPorts)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .in_port_i       (in_port_i),
    .msg_valid_i     (msg_valid_i),
    .msg_type_i      (msg_type_i),
    .msg_channel_i   (msg_channel_i),
    .data_one_i      (data_one_i),
    .data_two_i      (data_two_i),
    .out_port_i      (out_port_i),
    .route_enable_i  (route_enable_i),
    .target_channel_i(target_channel_i),
    .strobe_o        (strobe_o),
    .dest_port_o     (dest_port_o),
    .out_type_o      (out_type_o),
    .out_channel_o   (out_channel_o),
    .out_data_one_o  (out_data_one_o),
    .out_data_two_o  (out_data_two_o),
    .last_o          (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void reset_tables();
    for (int i = 0; i < int'(InPorts); i++) begin
      for (int o = 0; o < int'(OutPorts); o++) begin
        if (o == int'(UsbDest)) begin
          route_en[i][o] = (i != int'(mpcr_pkg::UsbInPort));
        end else begin
          route_en[i][o] = (i != o);
        end
        for (int c = 0; c < int'(mpcr_pkg::Channels); c++) begin
          chan_map[i][o][c] = mpcr_pkg::ChanW'(c + 1);
        end
      end
    end
  endfunction

  // Update the tables for one beat and queue the copies it forwards.
  function automatic void apply_beat(beat_t b);
    copy_t held;
    bit    have_held;
    logic [mpcr_pkg::ChanW-1:0] oc;
    have_held = 1'b0;
    if (b.port >= InPorts) return;
    if (b.cmd == CmdWrite) begin
      if (b.wport >= OutPorts || b.chan < 1 || b.chan > mpcr_pkg::Channels) return;
      route_en[b.port][b.wport] = b.wen;
      chan_map[b.port][b.wport][b.chan - 1] = b.wtarget;
      return;
    end
    if (!b.vld || b.mtype == TypeNone) return;
    for (int d = 0; d < int'(OutPorts); d++) begin
      if (!route_en[b.port][d]) continue;
      if (b.mtype >= mpcr_pkg::SysBase) begin
        if (d == int'(UsbDest) && b.mtype == mpcr_pkg::SysexType) continue;
        oc = b.chan;
      end else begin
        if (b.chan < 1 || b.chan > mpcr_pkg::Channels) continue;
        oc = chan_map[b.port][d][b.chan - 1];
        if (oc < 1 || oc > mpcr_pkg::Channels) continue;
      end
      if (have_held) copies_q.push_back(held);
      held = '{dest: DestW'(d), mtype: b.mtype, chan: oc, d1: b.d1, d2: b.d2, last: 1'b0};
      have_held = 1'b1;
    end
    if (have_held) begin
      held.last = 1'b1;
      copies_q.push_back(held);
    end
  endfunction

  function automatic beat_t noise_beat();
    beat_t b;
    b.cmd     = 1'($urandom);
    b.port    = mpcr_pkg::PortW'($urandom);
    b.vld     = 1'($urandom);
    b.mtype   = mpcr_pkg::TypeW'($urandom);
    b.chan    = mpcr_pkg::ChanW'($urandom);
    b.d1      = mpcr_pkg::DataW'($urandom);
    b.d2      = mpcr_pkg::DataW'($urandom);
    b.wport   = DestW'($urandom);
    b.wen     = 1'($urandom);
    b.wtarget = mpcr_pkg::ChanW'($urandom);
    return b;
  endfunction

  function automatic beat_t route_beat(int port, logic [mpcr_pkg::TypeW-1:0] mtype,
                                       int chan, int d1, int d2);
    beat_t b;
    b       = noise_beat();
    b.cmd   = CmdRoute;
    b.port  = mpcr_pkg::PortW'(port);
    b.vld   = 1'b1;
    b.mtype = mtype;
    b.chan  = mpcr_pkg::ChanW'(chan);
    b.d1    = mpcr_pkg::DataW'(d1);
    b.d2    = mpcr_pkg::DataW'(d2);
    return b;
  endfunction

  function automatic beat_t write_beat(int port, int wport, int chan, bit wen, int target);
    beat_t b;
    b         = noise_beat();
    b.cmd     = CmdWrite;
    b.port    = mpcr_pkg::PortW'(port);
    b.wport   = DestW'(wport);
    b.chan    = mpcr_pkg::ChanW'(chan);
    b.wen     = wen;
    b.wtarget = mpcr_pkg::ChanW'(target);
    return b;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // Driver: present the oldest pending beat, with random idle bursts.
  always @(negedge clk_i) begin
    beat_t b;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending_q.size() == 0) begin
      start <= 1'b0;
    end else if (pending_q.size() > CalmTail && $urandom_range(0, 9) == 0) begin
      gap_left = $urandom_range(1, 19) - 1;
      start <= 1'b0;
    end else begin
      b = pending_q[0];
      command_i        <= b.cmd;
      in_port_i        <= b.port;
      msg_valid_i      <= b.vld;
      msg_type_i       <= b.mtype;
      msg_channel_i    <= b.chan;
      data_one_i       <= b.d1;
      data_two_i       <= b.d2;
      out_port_i       <= b.wport;
      route_enable_i   <= b.wen;
      target_channel_i <= b.wtarget;
      start            <= 1'b1;
    end
  end

  // Monitor: check each strobed copy, then take the accepted beat.
  always @(posedge clk_i) begin
    copy_t want;
    if (rst_ni) begin
      if (strobe_o) begin
        if (copies_q.size() == 0) begin
          $display("%0t: unexpected copy dest %0d type %0h chan %0d", $time,
                   dest_port_o, out_type_o, out_channel_o);
          n_errors++;
        end else begin
          want = copies_q.pop_front();
          check_field("dest_port", want.dest, dest_port_o);
          check_field("out_type", want.mtype, out_type_o);
          check_field("out_channel", want.chan, out_channel_o);
          check_field("out_data_one", want.d1, out_data_one_o);
          check_field("out_data_two", want.d2, out_data_two_o);
          check_field("last", want.last, last_o);
        end
      end
      if (start && !busy) apply_beat(pending_q.pop_front());
    end
  end

  initial begin
    beat_t b;
    int    sel;
    logic [mpcr_pkg::TypeW-1:0] mtype;
    int    chan;
    int    target;
    reset_tables();

    pending_q.push_back(route_beat(0, NoteOn, 1, 0, 0));
    pending_q.push_back(route_beat(int'(mpcr_pkg::UsbInPort), NoteOff, 16, 127, 127));
    pending_q.push_back(route_beat(5, mpcr_pkg::SysexType, 0, 127, 0));
    pending_q.push_back(route_beat(9, SysReset, 31, 0, 127));
    pending_q.push_back(route_beat(4, TimingClk, 16, 64, 64));
    b = route_beat(1, PolyPress, 2, 10, 20);
    b.vld = 1'b0;
    pending_q.push_back(b);
    pending_q.push_back(route_beat(1, TypeNone, 2, 10, 20));
    pending_q.push_back(route_beat(15, NoteOn, 1, 1, 1));
    pending_q.push_back(route_beat(6, CtrlChange, 0, 5, 5));
    pending_q.push_back(route_beat(6, ChanPress, 17, 5, 5));
    // drop, out-of-range map value, remap and disable
    pending_q.push_back(write_beat(2, UsbDest, 3, 1'b1, ChanDrop));
    pending_q.push_back(route_beat(2, CtrlChange, 3, 7, 8));
    pending_q.push_back(write_beat(2, 0, 5, 1'b1, 0));
    pending_q.push_back(route_beat(2, PitchBend, 5, 9, 10));
    pending_q.push_back(write_beat(3, 1, 16, 1'b1, 1));
    pending_q.push_back(route_beat(3, PitchBend, 16, 11, 12));
    pending_q.push_back(write_beat(4, 2, 1, 1'b0, 9));
    pending_q.push_back(route_beat(4, ProgChange, 1, 13, 14));
    pending_q.push_back(write_beat(0, 0, 2, 1'b1, 31));
    pending_q.push_back(route_beat(0, NoteOn, 2, 15, 16));
    // writes that must be ignored
    pending_q.push_back(write_beat(1, 7, 4, 1'b0, ChanDrop));
    pending_q.push_back(write_beat(1, 1, 0, 1'b0, ChanDrop));
    pending_q.push_back(write_beat(1, 1, 17, 1'b0, ChanDrop));
    pending_q.push_back(write_beat(12, 1, 4, 1'b0, ChanDrop));
    pending_q.push_back(route_beat(1, NoteOn, 4, 17, 18));

    while (pending_q.size() < NumItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        if ($urandom_range(0, 3) != 0) begin
          mtype = {4'($urandom_range(8, 14)), 4'h0};
        end else begin
          mtype = {4'hF, 4'($urandom)};
        end
        chan = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        b = route_beat($urandom_range(0, InPorts - 1), mtype, chan,
                       $urandom_range(0, 127), $urandom_range(0, 127));
      end else if (sel < 88) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) target = $urandom_range(0, 31);
        else if (sel < 3) target = ChanDrop;
        else target = $urandom_range(1, 16);
        b = write_beat($urandom_range(0, InPorts - 1), $urandom_range(0, OutPorts - 1),
                       $urandom_range(1, 16), $urandom_range(0, 3) != 0, target);
      end else begin
        b = noise_beat();
      end
      pending_q.push_back(b);
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() != 0) @(posedge clk_i);
    while (copies_q.size() != 0) @(posedge clk_i);
    // let queued beats with no copies drain
    repeat (40) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mpcr_pkg.sv
hw/rtl/mpcr_ram.sv
hw/rtl/mpcr_front.sv
hw/rtl/mpcr_fifo.sv
hw/rtl/mpcr_back.sv
hw/rtl/midi_port_channel_router.sv
test/testbench.sv
